/* src/gmsd_pkg.sv */
// shared types, constants and helper functions of the grid min-steps block
package gmsd_pkg;

    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 1024;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int STEP_W   = 11;
    localparam int CFG_W    = 11;
    localparam int ADDR_W   = 3;

    localparam logic [STEP_W-1:0] STEP_MAX = {STEP_W{1'b1}};

    // register indexes on the configuration port
    localparam logic REG_GRID_ROWS = 1'b0;
    localparam logic REG_GRID_COLS = 1'b1;

    // one classified cell on its way from the front to the back
    typedef struct packed {
        logic             open;
        logic             row_first;
        logic             col_first;
        logic             last;
        logic [COL_W-1:0] col;
    } cell_item_t;

    // grid size register to last row index, zero read as one, large values clamped
    function automatic logic [ROW_W-1:0] rows_last(input logic [CFG_W-1:0] v);
        logic [ROW_W-1:0] r;
        if (v == '0)
            r = '0;
        else if (32'(v) > MAX_ROWS)
            r = ROW_W'(MAX_ROWS - 1);
        else
            r = ROW_W'(v - 1'b1);
        return r;
    endfunction

    // grid size register to last column index
    function automatic logic [COL_W-1:0] cols_last(input logic [CFG_W-1:0] v);
        logic [COL_W-1:0] r;
        if (v == '0)
            r = '0;
        else if (32'(v) > MAX_COLS)
            r = COL_W'(MAX_COLS - 1);
        else
            r = COL_W'(v - 1'b1);
        return r;
    endfunction

    // smaller of two step counts, zero meaning unreachable
    function automatic logic [STEP_W-1:0] min_reach(input logic [STEP_W-1:0] a,
                                                    input logic [STEP_W-1:0] b);
        logic [STEP_W-1:0] r;
        if (a == '0)
            r = b;
        else if (b == '0)
            r = a;
        else if (a < b)
            r = a;
        else
            r = b;
        return r;
    endfunction

endpackage

/* src/gmsd_front.sv */
// front end: accepts cell requests, tracks the raster position and classifies each cell
module gmsd_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       restart,
    input  logic [gmsd_pkg::ROW_W-1:0] rows_m1,
    input  logic [gmsd_pkg::COL_W-1:0] cols_m1,
    input  logic                       cell_valid,
    output logic                       cell_stall,
    input  logic                       cell_open,
    output logic                       push,
    output gmsd_pkg::cell_item_t       push_item,
    input  logic                       queue_full
);

    logic [gmsd_pkg::ROW_W-1:0] row_reg, row_next;
    logic [gmsd_pkg::COL_W-1:0] col_reg, col_next;
    logic                       at_row_end;
    logic                       at_col_end;

    assign cell_stall = queue_full;
    assign push       = cell_valid && !queue_full;

    assign at_row_end = (row_reg == rows_m1);
    assign at_col_end = (col_reg == cols_m1);

    // classify the cell at the current position
    always_comb
    begin
        push_item.open      = cell_open;
        push_item.row_first = (row_reg == '0);
        push_item.col_first = (col_reg == '0);
        push_item.last      = at_row_end && at_col_end;
        push_item.col       = col_reg;
    end

    // raster position of the next cell, wrapping at the grid end
    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (restart)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (push)
        begin
            if (at_col_end)
            begin
                col_next = '0;
                row_next = at_row_end ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule

/* src/gmsd_queue.sv */
// two-entry queue of classified cells between the front and the back
module gmsd_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  gmsd_pkg::cell_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 head_valid,
    output gmsd_pkg::cell_item_t head_item
);

    gmsd_pkg::cell_item_t entry_reg [2];
    logic                 wr_ptr_reg, wr_ptr_next;
    logic                 rd_ptr_reg, rd_ptr_next;
    logic [1:0]           count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_item  = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

/* src/gmsd_back.sv */
// back end: line buffer read, three-way minimum, increment and result register
module gmsd_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        head_valid,
    input  gmsd_pkg::cell_item_t        head_item,
    output logic                        pop,
    output logic                        step_valid,
    input  logic                        step_stall,
    output logic [gmsd_pkg::STEP_W-1:0] steps,
    output logic                        last_cell
);

    logic [gmsd_pkg::STEP_W-1:0] line_mem [gmsd_pkg::MAX_COLS];
    logic [gmsd_pkg::STEP_W-1:0] rd_data_reg;
    logic                        byp_hit_reg;
    logic [gmsd_pkg::STEP_W-1:0] byp_data_reg;

    gmsd_pkg::cell_item_t        b_item_reg;
    logic                        b_valid_reg, b_valid_next;
    logic                        b_adv;

    logic [gmsd_pkg::STEP_W-1:0] left_reg;
    logic [gmsd_pkg::STEP_W-1:0] diag_reg;

    logic                        out_valid_reg, out_valid_next;
    logic [gmsd_pkg::STEP_W-1:0] out_steps_reg;
    logic                        out_last_reg;

    logic [gmsd_pkg::STEP_W-1:0] up_raw;
    logic [gmsd_pkg::STEP_W-1:0] up_val;
    logic [gmsd_pkg::STEP_W-1:0] left_val;
    logic [gmsd_pkg::STEP_W-1:0] diag_val;
    logic [gmsd_pkg::STEP_W-1:0] best;
    logic [gmsd_pkg::STEP_W-1:0] result;

    // pipeline advance: result register free, then a new cell may enter
    assign b_adv = b_valid_reg && (!out_valid_reg || !step_stall);
    assign pop   = head_valid && (!b_valid_reg || b_adv);

    // line buffer value, forwarded when the same column was written as it was read
    assign up_raw   = byp_hit_reg ? byp_data_reg : rd_data_reg;
    assign up_val   = b_item_reg.row_first ? '0 : up_raw;
    assign left_val = b_item_reg.col_first ? '0 : left_reg;
    assign diag_val = (b_item_reg.row_first || b_item_reg.col_first) ? '0 : diag_reg;

    // fewest steps to this cell, saturating
    always_comb
    begin
        best = gmsd_pkg::min_reach(left_val, gmsd_pkg::min_reach(up_val, diag_val));
        if (!b_item_reg.open)
            result = '0;
        else if (b_item_reg.row_first && b_item_reg.col_first)
            result = gmsd_pkg::STEP_W'(1);
        else if (best == '0)
            result = '0;
        else if (best == gmsd_pkg::STEP_MAX)
            result = gmsd_pkg::STEP_MAX;
        else
            result = best + 1'b1;
    end

    // line buffer: written by the computing stage, read as a cell enters it
    always_ff @(posedge clk)
    begin
        if (b_adv)
            line_mem[b_item_reg.col] <= result;
        if (pop)
            rd_data_reg <= line_mem[head_item.col];
    end

    // forwarding capture and stage payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b_item_reg   <= head_item;
            byp_hit_reg  <= b_adv && (b_item_reg.col == head_item.col);
            byp_data_reg <= result;
        end
        if (b_adv)
        begin
            left_reg      <= result;
            diag_reg      <= up_val;
            out_steps_reg <= result;
            out_last_reg  <= b_item_reg.last;
        end
    end

    // stage and result valid flags
    always_comb
    begin
        b_valid_next = b_valid_reg;
        if (pop)
            b_valid_next = 1'b1;
        else if (b_adv)
            b_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (b_adv)
            out_valid_next = 1'b1;
        else if (!step_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign step_valid = out_valid_reg;
    assign steps      = out_steps_reg;
    assign last_cell  = out_last_reg;

endmodule

/* src/grid_min_steps_dp.sv */
// top level of the grid min-steps block: configuration registers, front, queue and back
// Takes grid cells in row-major order, one open/blocked bit per cell request, and returns
// for each cell the fewest cells on a right/down/diagonal path from the top-left corner
// (start counts 1, blocked or unreachable gives 0, saturating at 2047); last_cell marks
// the bottom-right cell whose steps is the answer. One cell is accepted every clock and
// one result leaves every clock while the result side does not stall; a result is
// offered once its cell has passed the queue write, the line-buffer read and the compute
// into the output register, in that order. The rate of one cell per cycle comes
// from one read and one write of the one-row line buffer per cycle, with the three-way
// minimum and increment in a single stage. grid_rows (address 0) and grid_cols
// (address 4) are clamped to 1..1024; writing either restarts the raster at the
// top-left cell, and it should be done only while the block is idle.
module grid_min_steps_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gmsd_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        cell_valid,
    output logic                        cell_stall,
    input  logic                        cell_open,
    output logic                        step_valid,
    input  logic                        step_stall,
    output logic [gmsd_pkg::STEP_W-1:0] steps,
    output logic                        last_cell
);

    logic [gmsd_pkg::CFG_W-1:0] grid_rows_reg, grid_rows_next;
    logic [gmsd_pkg::CFG_W-1:0] grid_cols_reg, grid_cols_next;
    logic                       cfg_wr;
    logic                       reg_sel;

    logic [gmsd_pkg::ROW_W-1:0] rows_m1;
    logic [gmsd_pkg::COL_W-1:0] cols_m1;

    logic                       push;
    gmsd_pkg::cell_item_t       push_item;
    logic                       queue_full;
    logic                       pop;
    logic                       head_valid;
    gmsd_pkg::cell_item_t       head_item;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    // register write decode
    always_comb
    begin
        grid_rows_next = grid_rows_reg;
        grid_cols_next = grid_cols_reg;
        if (cfg_wr)
        begin
            unique case (reg_sel)
                gmsd_pkg::REG_GRID_ROWS: grid_rows_next = pwdata[gmsd_pkg::CFG_W-1:0];
                gmsd_pkg::REG_GRID_COLS: grid_cols_next = pwdata[gmsd_pkg::CFG_W-1:0];
                default:                 grid_rows_next = grid_rows_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= gmsd_pkg::CFG_W'(1);
            grid_cols_reg <= gmsd_pkg::CFG_W'(1);
        end
        else
        begin
            grid_rows_reg <= grid_rows_next;
            grid_cols_reg <= grid_cols_next;
        end
    end

    // register read-back
    always_comb
    begin
        unique case (reg_sel)
            gmsd_pkg::REG_GRID_ROWS: prdata = 32'(grid_rows_reg);
            gmsd_pkg::REG_GRID_COLS: prdata = 32'(grid_cols_reg);
            default:                 prdata = '0;
        endcase
    end

    // effective grid size
    assign rows_m1 = gmsd_pkg::rows_last(grid_rows_reg);
    assign cols_m1 = gmsd_pkg::cols_last(grid_cols_reg);

    gmsd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .restart    (cfg_wr),
        .rows_m1    (rows_m1),
        .cols_m1    (cols_m1),
        .cell_valid (cell_valid),
        .cell_stall (cell_stall),
        .cell_open  (cell_open),
        .push       (push),
        .push_item  (push_item),
        .queue_full (queue_full)
    );

    gmsd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    gmsd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .step_valid (step_valid),
        .step_stall (step_stall),
        .steps      (steps),
        .last_cell  (last_cell)
    );

endmodule
